@@ rtl/core/sbc_pkg.sv @@
// ============================================================================
// sbc_pkg: shared types and constants for the source bracket checker
// Holds the scan mode, the stack command passed from the front to the back,
// the result word, the bracket marks, the error codes and the character codes.
// ============================================================================
package sbc_pkg;

    // Scan mode of the front part.
    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'b0001,
        MODE_COMMENT = 4'b0010,
        MODE_STRING  = 4'b0100,
        MODE_ESCAPE  = 4'b1000
    } scan_mode_t;

    // Stack operation decoded by the front part.
    typedef enum logic [2:0] {
        OP_NONE        = 3'd0,
        OP_PUSH_SQUARE = 3'd1,
        OP_PUSH_ROUND  = 3'd2,
        OP_POP_SQUARE  = 3'd3,
        OP_POP_LOOP    = 3'd4,
        OP_LOOP_MARK   = 3'd5,
        OP_END_CHECK   = 3'd6,
        OP_END_PLAIN   = 3'd7
    } stack_op_t;

    // Bracket marks kept on the stack.
    localparam logic [1:0] MARK_SQUARE = 2'd0;
    localparam logic [1:0] MARK_ROUND  = 2'd1;
    localparam logic [1:0] MARK_LOOP   = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_ESCAPE_END  = 3'd1;
    localparam logic [2:0] ERR_OPEN_STRING = 3'd2;
    localparam logic [2:0] ERR_TOO_DEEP    = 3'd3;
    localparam logic [2:0] ERR_BAD_CLOSE   = 3'd4;
    localparam logic [2:0] ERR_BAD_LOOP    = 3'd5;
    localparam logic [2:0] ERR_LEFT_OPEN   = 3'd6;
    localparam logic [2:0] ERR_HIGH_BYTE   = 3'd7;

    // Character codes.
    localparam logic [7:0] CH_END_TOKEN   = 8'h7f;
    localparam logic [7:0] CH_SPACE       = 8'h20;
    localparam logic [7:0] CH_ZERO        = 8'h00;
    localparam logic [7:0] CH_OPEN_BRACE  = 8'h7b;
    localparam logic [7:0] CH_CLOSE_BRACE = 8'h7d;
    localparam logic [7:0] CH_APOSTROPHE  = 8'h27;
    localparam logic [7:0] CH_QUOTE       = 8'h22;
    localparam logic [7:0] CH_OPEN_SQ     = 8'h5b;
    localparam logic [7:0] CH_CLOSE_SQ    = 8'h5d;
    localparam logic [7:0] CH_OPEN_RD     = 8'h28;
    localparam logic [7:0] CH_CLOSE_RD    = 8'h29;
    localparam logic [7:0] CH_HASH        = 8'h23;

    // Word passed from the front part to the back part.
    typedef struct packed {
        logic [7:0] cleaned;
        stack_op_t  op;
        logic [2:0] err;
    } stack_cmd_t;

    // Result word.
    typedef struct packed {
        logic [7:0] cleaned_byte;
        logic [2:0] error_code;
        logic       end_seen;
    } result_t;

    // Status of the back part.
    typedef struct packed {
        logic       depth_zero;
        logic [2:0] err_kept;
    } back_status_t;

endpackage

@@ rtl/core/source_bracket_checker.sv @@
// ============================================================================
// source_bracket_checker: comment strip and bracket balance checker
// Cleans program text byte by byte and checks bracket nesting and loop marks.
// ============================================================================
// The block takes one source byte per clock cycle while full is low and
// returns one result word per byte, in order, at a sustained rate of one
// word per cycle while the result side keeps popping. A byte's result word
// reaches the result ports through both queues: the front classifier writes
// the queue between the parts at the accepting edge, and the bracket stack
// unit writes the result queue when it fires. The stack memory is either read
// or written once in each cycle the back part fires, with the top entries held
// in registers. Each side is a two-entry queue, so full and empty depend only
// on the local fill counts. The stack needs no clearing after reset, and the
// end token (0x7f) returns the block to its reset state after its own result
// word, which carries the final error code with end_seen set. Nesting beyond
// MAX_NESTING gives the nesting-too-deep error.
module source_bracket_checker #(
    parameter int MAX_NESTING = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] source_byte,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] cleaned_byte,
    output logic [2:0] error_code,
    output logic       end_seen
);

    import sbc_pkg::*;

    logic         in_accept;
    stack_cmd_t   front_cmd;
    stack_cmd_t   back_cmd;
    logic         mid_empty;
    logic         out_full;
    logic         back_fire;
    result_t      back_res;
    result_t      out_res;
    back_status_t back_stat;

    assign in_accept = push && !full;
    assign back_fire = !mid_empty && !out_full;

    // Front: mode tracking and classification.
    sbc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .source_byte (source_byte),
        .cmd         (front_cmd)
    );

    // Queue between the front and the back.
    sbc_fifo #(
        .WIDTH ($bits(stack_cmd_t))
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_accept),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (back_fire),
        .rd_data (back_cmd),
        .empty   (mid_empty)
    );

    // Back: bracket stack and error keeping.
    sbc_back #(
        .MAX_NESTING (MAX_NESTING)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (back_fire),
        .cmd    (back_cmd),
        .res    (back_res),
        .status (back_stat)
    );

    // Result queue.
    sbc_fifo #(
        .WIDTH ($bits(result_t))
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (back_fire),
        .wr_data (back_res),
        .full    (out_full),
        .rd_en   (pop && !empty),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign cleaned_byte = out_res.cleaned_byte;
    assign error_code   = out_res.error_code;
    assign end_seen     = out_res.end_seen;

    // The end token leaves an empty stack and no kept error.
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (back_fire && back_res.end_seen) |=>
            (back_stat.depth_zero && back_stat.err_kept == ERR_NONE))
        else $error("end token did not reset the checker");

    // A kept error holds until the end token.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (back_stat.err_kept != ERR_NONE && !(back_fire && back_res.end_seen)) |=>
            $stable(back_stat.err_kept))
        else $error("kept error changed before the end token");

    // A word fired while an error is kept carries that kept error.
    a_error_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (back_fire && back_stat.err_kept != ERR_NONE) |->
            (back_res.error_code == back_stat.err_kept))
        else $error("result word lost the kept error");

endmodule

@@ rtl/core/sbc_fifo.sv @@
// ============================================================================
// sbc_fifo: two-entry word queue
// Registered storage with separate read and write pointers. Full and empty
// depend on the fill count only, so neither side sees a path from the other.
// ============================================================================
module sbc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Word storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/core/sbc_front.sv @@
// ============================================================================
// sbc_front: scan mode tracker and byte classifier
// Follows comments, strings and quote-escapes, cleans each byte and decodes
// the stack operation and any error that is known from the byte alone.
// ============================================================================
module sbc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         source_byte,
    output sbc_pkg::stack_cmd_t cmd
);

    import sbc_pkg::*;

    scan_mode_t mode_reg;
    scan_mode_t mode_next;

    // Classify the byte according to the current mode.
    always_comb
    begin
        mode_next   = mode_reg;
        cmd.cleaned = source_byte;
        cmd.op      = OP_NONE;
        cmd.err     = ERR_NONE;
        unique case (mode_reg)
            MODE_COMMENT:
            begin
                if (source_byte == CH_END_TOKEN)
                begin
                    cmd.op    = OP_END_CHECK;
                    mode_next = MODE_NORMAL;
                end
                else
                begin
                    cmd.cleaned = CH_SPACE;
                    if (source_byte == CH_CLOSE_BRACE)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
            end
            MODE_STRING:
            begin
                if (source_byte == CH_END_TOKEN)
                begin
                    cmd.op    = OP_END_PLAIN;
                    cmd.err   = ERR_OPEN_STRING;
                    mode_next = MODE_NORMAL;
                end
                else if (source_byte == CH_QUOTE)
                begin
                    cmd.cleaned = CH_ZERO;
                    mode_next   = MODE_NORMAL;
                end
            end
            MODE_ESCAPE:
            begin
                mode_next = MODE_NORMAL;
                if (source_byte == CH_END_TOKEN)
                begin
                    cmd.op  = OP_END_PLAIN;
                    cmd.err = ERR_ESCAPE_END;
                end
            end
            MODE_NORMAL:
            begin
                case (source_byte)
                    CH_OPEN_BRACE:
                    begin
                        cmd.cleaned = CH_SPACE;
                        mode_next   = MODE_COMMENT;
                    end
                    CH_APOSTROPHE: mode_next = MODE_ESCAPE;
                    CH_QUOTE:      mode_next = MODE_STRING;
                    CH_OPEN_SQ:    cmd.op = OP_PUSH_SQUARE;
                    CH_OPEN_RD:    cmd.op = OP_PUSH_ROUND;
                    CH_CLOSE_SQ:   cmd.op = OP_POP_SQUARE;
                    CH_CLOSE_RD:   cmd.op = OP_POP_LOOP;
                    CH_HASH:       cmd.op = OP_LOOP_MARK;
                    CH_END_TOKEN:  cmd.op = OP_END_CHECK;
                    default:
                    begin
                        if (source_byte[7])
                        begin
                            cmd.err = ERR_HIGH_BYTE;
                        end
                    end
                endcase
            end
            default:
            begin
                mode_next = MODE_NORMAL;
            end
        endcase
    end

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

@@ rtl/core/sbc_back.sv @@
// ============================================================================
// sbc_back: bracket stack and error keeper
// Carries out one stack command per cycle while fire is high. The top mark
// and the mark below it sit in registers, the rest in a memory whose
// registered read prefetches the entry below the top when it is not written.
// ============================================================================
module sbc_back #(
    parameter int MAX_NESTING = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  sbc_pkg::stack_cmd_t   cmd,
    output sbc_pkg::result_t      res,
    output sbc_pkg::back_status_t status
);

    import sbc_pkg::*;

    localparam int DW = $clog2(MAX_NESTING + 1);
    localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

    logic [1:0]    stack_mem [MAX_NESTING];
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] depth_next;
    logic [1:0]    top_reg;
    logic [1:0]    top_next;
    logic [1:0]    below_reg;
    logic [2:0]    err_reg;
    logic [2:0]    err_new;
    logic [2:0]    err_out;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          end_flag;

    // Execute the stack command.
    always_comb
    begin
        depth_next = depth_reg;
        top_next   = top_reg;
        err_new    = cmd.err;
        wr_en      = 1'b0;
        end_flag   = 1'b0;
        unique case (cmd.op)
            OP_PUSH_SQUARE, OP_PUSH_ROUND:
            begin
                if (depth_reg == DW'(MAX_NESTING))
                begin
                    err_new = ERR_TOO_DEEP;
                end
                else
                begin
                    wr_en      = (depth_reg != '0);
                    top_next   = (cmd.op == OP_PUSH_SQUARE) ? MARK_SQUARE : MARK_ROUND;
                    depth_next = depth_reg + DW'(1);
                end
            end
            OP_POP_SQUARE, OP_POP_LOOP:
            begin
                if (depth_reg == '0)
                begin
                    err_new = ERR_BAD_CLOSE;
                end
                else
                begin
                    depth_next = depth_reg - DW'(1);
                    top_next   = below_reg;
                    if (top_reg != ((cmd.op == OP_POP_SQUARE) ? MARK_SQUARE : MARK_LOOP))
                    begin
                        err_new = ERR_BAD_CLOSE;
                    end
                end
            end
            OP_LOOP_MARK:
            begin
                if (depth_reg == '0)
                begin
                    err_new = ERR_BAD_LOOP;
                end
                else
                begin
                    if (top_reg != MARK_ROUND)
                    begin
                        err_new = ERR_BAD_LOOP;
                    end
                    top_next = MARK_LOOP;
                end
            end
            OP_END_CHECK:
            begin
                end_flag = 1'b1;
                if (depth_reg != '0)
                begin
                    err_new = ERR_LEFT_OPEN;
                end
            end
            OP_END_PLAIN:
            begin
                end_flag = 1'b1;
            end
            default:
            begin
                depth_next = depth_reg;
            end
        endcase
    end

    // The first error is kept.
    assign err_out = (err_reg != ERR_NONE) ? err_reg : err_new;

    // A push stores the old top just below the new one; the read prefetches
    // the entry that sits below the next top.
    assign wr_addr = AW'(depth_reg - DW'(1));
    assign rd_addr = AW'(depth_next - DW'(2));

    assign res.cleaned_byte = cmd.cleaned;
    assign res.error_code   = err_out;
    assign res.end_seen     = end_flag;

    assign status.depth_zero = (depth_reg == '0);
    assign status.err_kept   = err_reg;

    // Depth and error; the end token returns both to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            err_reg   <= ERR_NONE;
        end
        else if (fire)
        begin
            if (end_flag)
            begin
                depth_reg <= '0;
                err_reg   <= ERR_NONE;
            end
            else
            begin
                depth_reg <= depth_next;
                err_reg   <= err_out;
            end
        end
    end

    // Stack memory with the top and prefetched entry registers.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            top_reg <= top_next;
            if (wr_en)
            begin
                stack_mem[wr_addr] <= top_reg;
                below_reg          <= top_reg;
            end
            else
            begin
                below_reg <= stack_mem[rd_addr];
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for source_bracket_checker
// Feeds program text bytes through the push side and checks every result word
// against a scoreboard that tracks the scan mode, the bracket stack and the
// first error. Directed cases come first, then a full-depth nesting run, then
// random programs under several idle and stall patterns.
// ============================================================================
module testbench;

    import sbc_pkg::*;

    localparam int STACK_SLOTS = 1024;

    // Scoreboard: predicts one result word per accepted byte and checks them.
    class bracket_scoreboard;
        scan_mode_t  mode;
        logic [1:0]  marks [STACK_SLOTS];
        int unsigned depth;
        logic [2:0]  first_err;
        result_t     expected_words[$];
        int unsigned mismatch_count;

        function new();
            mismatch_count = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            mode      = MODE_NORMAL;
            depth     = 0;
            first_err = ERR_NONE;
        endfunction

        function void keep_error(logic [2:0] code);
            if (first_err == ERR_NONE)
                first_err = code;
        endfunction

        function void open_mark(logic [1:0] m);
            if (depth >= STACK_SLOTS)
            begin
                keep_error(ERR_TOO_DEEP);
            end
            else
            begin
                marks[depth] = m;
                depth++;
            end
        endfunction

        function void close_mark(logic [1:0] m);
            if (depth == 0)
            begin
                keep_error(ERR_BAD_CLOSE);
            end
            else
            begin
                depth--;
                if (marks[depth] != m)
                    keep_error(ERR_BAD_CLOSE);
            end
        endfunction

        // Works out the result word for one accepted source byte.
        function void note_byte(logic [7:0] b);
            result_t word;
            logic    last;
            word.cleaned_byte = b;
            last = 1'b0;
            case (mode)
                MODE_COMMENT:
                begin
                    if (b == CH_END_TOKEN)
                    begin
                        last = 1'b1;
                        if (depth != 0)
                            keep_error(ERR_LEFT_OPEN);
                    end
                    else
                    begin
                        word.cleaned_byte = CH_SPACE;
                        if (b == CH_CLOSE_BRACE)
                            mode = MODE_NORMAL;
                    end
                end
                MODE_STRING:
                begin
                    if (b == CH_END_TOKEN)
                    begin
                        last = 1'b1;
                        keep_error(ERR_OPEN_STRING);
                    end
                    else if (b == CH_QUOTE)
                    begin
                        word.cleaned_byte = CH_ZERO;
                        mode = MODE_NORMAL;
                    end
                end
                MODE_ESCAPE:
                begin
                    if (b == CH_END_TOKEN)
                    begin
                        last = 1'b1;
                        keep_error(ERR_ESCAPE_END);
                    end
                    else
                    begin
                        mode = MODE_NORMAL;
                    end
                end
                default:
                begin
                    case (b)
                        CH_OPEN_BRACE:
                        begin
                            word.cleaned_byte = CH_SPACE;
                            mode = MODE_COMMENT;
                        end
                        CH_APOSTROPHE: mode = MODE_ESCAPE;
                        CH_QUOTE:      mode = MODE_STRING;
                        CH_OPEN_SQ:    open_mark(MARK_SQUARE);
                        CH_OPEN_RD:    open_mark(MARK_ROUND);
                        CH_CLOSE_SQ:   close_mark(MARK_SQUARE);
                        CH_CLOSE_RD:   close_mark(MARK_LOOP);
                        CH_HASH:
                        begin
                            // A loop mark on a wrong top is an error but still rewrites it.
                            if (depth == 0)
                            begin
                                keep_error(ERR_BAD_LOOP);
                            end
                            else
                            begin
                                if (marks[depth - 1] != MARK_ROUND)
                                    keep_error(ERR_BAD_LOOP);
                                marks[depth - 1] = MARK_LOOP;
                            end
                        end
                        CH_END_TOKEN:
                        begin
                            last = 1'b1;
                            if (depth != 0)
                                keep_error(ERR_LEFT_OPEN);
                        end
                        default:
                        begin
                            if (b[7])
                                keep_error(ERR_HIGH_BYTE);
                        end
                    endcase
                end
            endcase
            word.error_code = first_err;
            word.end_seen   = last;
            expected_words.push_back(word);
            if (last)
                clear_scan();
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns  mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        // Compares one accepted result word with the oldest expected word.
        task compare_word(result_t got);
            result_t want;
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("word %h with nothing outstanding", got));
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.cleaned_byte !== want.cleaned_byte)
                    report_mismatch($sformatf("cleaned_byte %h, expected %h",
                                              got.cleaned_byte, want.cleaned_byte));
                if (got.error_code !== want.error_code)
                    report_mismatch($sformatf("error_code %0d, expected %0d",
                                              got.error_code, want.error_code));
                if (got.end_seen !== want.end_seen)
                    report_mismatch($sformatf("end_seen %b, expected %b",
                                              got.end_seen, want.end_seen));
            end
        endtask

        task check_leftover();
            if (expected_words.size() != 0)
                report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] source_byte = 8'h00;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] cleaned_byte;
    logic [2:0] error_code;
    logic       end_seen;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int bytes_sent = 0;

    bracket_scoreboard sb = new();

    source_bracket_checker #(
        .MAX_NESTING(STACK_SLOTS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .source_byte (source_byte),
        .pop         (pop),
        .empty       (empty),
        .cleaned_byte(cleaned_byte),
        .error_code  (error_code),
        .end_seen    (end_seen)
    );

    always #4 clk = ~clk;

    // Result side: checks each popped word, then decides the next pop.
    // A requested hold-off keeps pop low until it has counted down.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.compare_word('{cleaned_byte, error_code, end_seen});
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offers one byte, idling first at random, and waits until it is taken.
    task send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        source_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    function automatic logic is_special(logic [7:0] b);
        case (b)
            CH_END_TOKEN, CH_OPEN_BRACE, CH_CLOSE_BRACE, CH_APOSTROPHE, CH_QUOTE,
            CH_OPEN_SQ, CH_CLOSE_SQ, CH_OPEN_RD, CH_CLOSE_RD, CH_HASH:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // Any byte but the end token and the given terminator.
    function automatic logic [7:0] filler_byte(logic [7:0] stop);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_END_TOKEN || b == stop)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Printable text with no meaning to the scanner.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(8'h20, 8'h7e));
        while (is_special(b))
            b = 8'($urandom_range(8'h20, 8'h7e));
        return b;
    endfunction

    // Sends one program ending in the end token. A tidy program is balanced;
    // an untidy one gets random noise, may leave marks open and may end
    // inside a string, a comment or an escape.
    task send_program(input int steps, input bit tidy);
        logic [1:0] opens[$];
        int         k;
        int         pick;
        int         n;
        bit         close_all;
        close_all = tidy || ($urandom_range(0, 1) == 1);
        k = 0;
        while (k < steps || (close_all && opens.size() > 0))
        begin
            pick = (k >= steps) ? 45 : $urandom_range(0, 99);
            if (!tidy && pick < 10)
            begin
                send_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 24 && opens.size() < 24)
            begin
                send_byte(CH_OPEN_SQ);
                opens.push_back(MARK_SQUARE);
            end
            else if (pick < 38 && opens.size() < 24)
            begin
                send_byte(CH_OPEN_RD);
                opens.push_back(MARK_ROUND);
            end
            else if (pick < 52 && opens.size() > 0)
            begin
                // Close the top mark; a plain round one needs its loop mark first.
                if (opens[opens.size() - 1] == MARK_SQUARE)
                begin
                    send_byte(CH_CLOSE_SQ);
                end
                else
                begin
                    if (opens[opens.size() - 1] == MARK_ROUND)
                        send_byte(CH_HASH);
                    send_byte(CH_CLOSE_RD);
                end
                void'(opens.pop_back());
            end
            else if (pick < 57 && opens.size() > 0 && opens[opens.size() - 1] == MARK_ROUND)
            begin
                send_byte(CH_HASH);
                opens[opens.size() - 1] = MARK_LOOP;
            end
            else if (pick < 64)
            begin
                send_byte(CH_OPEN_BRACE);
                n = $urandom_range(0, 6);
                repeat (n) send_byte(filler_byte(CH_CLOSE_BRACE));
                send_byte(CH_CLOSE_BRACE);
            end
            else if (pick < 71)
            begin
                send_byte(CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) send_byte(filler_byte(CH_QUOTE));
                send_byte(CH_QUOTE);
            end
            else if (pick < 77)
            begin
                send_byte(CH_APOSTROPHE);
                send_byte(filler_byte(CH_END_TOKEN));
            end
            else
            begin
                send_byte(plain_byte());
            end
            k++;
        end
        // Untidy programs may end inside a string, an escape or a comment.
        if (!tidy)
        begin
            n = $urandom_range(0, 3);
            case ($urandom_range(0, 5))
                0:
                begin
                    send_byte(CH_QUOTE);
                    repeat (n) send_byte(filler_byte(CH_QUOTE));
                end
                1: send_byte(CH_APOSTROPHE);
                2:
                begin
                    send_byte(CH_OPEN_BRACE);
                    repeat (n) send_byte(filler_byte(CH_CLOSE_BRACE));
                end
                default: ;
            endcase
        end
        send_byte(CH_END_TOKEN);
    endtask

    // Random programs until about the given number of bytes has gone in.
    task random_phase(input int quota);
        int start;
        int pick;
        int n;
        start = bytes_sent;
        while (bytes_sent - start < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                send_program($urandom_range(1, 40), 1'b1);
            end
            else if (pick < 90)
            begin
                send_program($urandom_range(1, 40), 1'b0);
            end
            else
            begin
                n = $urandom_range(1, 30);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
                send_byte(CH_END_TOKEN);
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        logic [7:0] script[$];
        int         waited;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases, each closed by the end token.
        script = '{CH_OPEN_RD, CH_HASH, CH_OPEN_BRACE, 8'hff, CH_CLOSE_BRACE,
                   CH_QUOTE, 8'h80, CH_QUOTE, CH_APOSTROPHE, 8'hff, CH_CLOSE_RD,
                   8'h00, CH_END_TOKEN,
                   CH_APOSTROPHE, CH_END_TOKEN,
                   CH_QUOTE, CH_END_TOKEN,
                   CH_HASH, CH_CLOSE_SQ, CH_END_TOKEN,
                   CH_OPEN_SQ, CH_CLOSE_RD, CH_END_TOKEN,
                   CH_OPEN_RD, CH_OPEN_BRACE, CH_END_TOKEN,
                   8'hff, CH_END_TOKEN};
        foreach (script[i])
            send_byte(script[i]);

        // Fill the stack to its limit, overflow it once, unwind part of it
        // and end with marks still open.
        repeat (STACK_SLOTS) send_byte(CH_OPEN_SQ);
        send_byte(CH_OPEN_RD);
        repeat (64) send_byte(CH_CLOSE_SQ);
        send_byte(CH_END_TOKEN);

        // Back-to-back traffic with one long hold-off on the result side.
        hold_request = 400;
        random_phase(60);

        send_idle_pct = 49;
        stall_pct = 0;
        random_phase(60);

        send_idle_pct = 0;
        stall_pct = 49;
        random_phase(60);

        send_idle_pct = 7;
        stall_pct = 7;
        random_phase(60);

        // Drain the outstanding words, then check that none is left.
        push <= 1'b0;
        stall_pct = 0;
        waited = 0;
        while (sb.expected_words.size() > 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        sb.check_leftover();
        if (sb.mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/sbc_pkg.sv
rtl/core/sbc_fifo.sv
rtl/core/sbc_front.sv
rtl/core/sbc_back.sv
rtl/core/source_bracket_checker.sv
tb/testbench.sv
